>>> rtl/core/dsc_pkg.sv
`default_nettype none

package dsc_pkg;

    localparam int unsigned MonthW  = 4;
    localparam int unsigned DayW    = 5;
    localparam int unsigned YearW   = 12;
    localparam int unsigned TotalW  = 21;
    localparam int unsigned LeapW   = 10;
    localparam int unsigned DoyW    = 9;
    localparam int unsigned Q100W   = 7;
    localparam int unsigned YearMax = 3000;
    localparam int unsigned MonthsPerYear = 12;
    localparam int unsigned DaysCommon = 365;
    localparam int unsigned DaysLeap   = 366;
    // x/100 == (x*5243) >> 19 for x below 43699
    localparam int unsigned Recip100     = 5243;
    localparam int unsigned Recip100Shift = 19;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_START = 2'd1,
        ST_BAD_END   = 2'd2,
        ST_ORDER     = 2'd3
    } t_status;

    typedef struct packed {
        logic               valid;
        logic               leap;
        logic [DoyW-1:0]    prior;       // days of the year before the month
        logic [LeapW-1:0]   leaps_thru;  // leap years from 1 to this year
    } t_date_info;

    typedef struct packed {
        logic [YearW-1:0]  years;
        logic [MonthW-1:0] months;
        logic [DayW-1:0]   days;
    } t_age;

    typedef struct packed {
        t_status           status;
        logic [TotalW-1:0] total_days;
        logic [LeapW-1:0]  leap_count;
        logic [DoyW-1:0]   days_before;
        logic [DoyW-1:0]   days_after;
        t_age              age;
    } t_res;

    function automatic logic [DayW-1:0] f_month_len_common(input logic [MonthW-1:0] m);
        logic [DayW-1:0] n;
        case (m)
            4'd2:    n = 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

    // days of a common year before the first of month m
    function automatic logic [DoyW-1:0] f_cum_days(input logic [MonthW-1:0] m);
        logic [DoyW-1:0] s;
        case (m)
            4'd1:    s = 9'd0;
            4'd2:    s = 9'd31;
            4'd3:    s = 9'd59;
            4'd4:    s = 9'd90;
            4'd5:    s = 9'd120;
            4'd6:    s = 9'd151;
            4'd7:    s = 9'd181;
            4'd8:    s = 9'd212;
            4'd9:    s = 9'd243;
            4'd10:   s = 9'd273;
            4'd11:   s = 9'd304;
            4'd12:   s = 9'd334;
            4'd13:   s = 9'd365;
            4'd14:   s = 9'd365;
            4'd15:   s = 9'd365;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    function automatic logic [Q100W-1:0] f_div100(input logic [YearW-1:0] y);
        logic [YearW+13:0] p;
        p = {14'd0, y} * (YearW+14)'(Recip100);
        return p[Recip100Shift +: Q100W];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/dsc_if.sv
`default_nettype none

interface dsc_req_if;
    logic                         valid;
    logic                         ready;
    logic [dsc_pkg::MonthW-1:0]   start_month;
    logic [dsc_pkg::DayW-1:0]     start_day;
    logic [dsc_pkg::YearW-1:0]    start_year;
    logic [dsc_pkg::MonthW-1:0]   end_month;
    logic [dsc_pkg::DayW-1:0]     end_day;
    logic [dsc_pkg::YearW-1:0]    end_year;

    modport source (
        output valid, start_month, start_day, start_year, end_month, end_day, end_year,
        input  ready
    );
    modport sink (
        input  valid, start_month, start_day, start_year, end_month, end_day, end_year,
        output ready
    );
endinterface

interface dsc_res_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic [dsc_pkg::TotalW-1:0]   total_days;
    logic [dsc_pkg::LeapW-1:0]    leap_count;
    logic [dsc_pkg::DoyW-1:0]     days_before;
    logic [dsc_pkg::DoyW-1:0]     days_after;
    logic [dsc_pkg::YearW-1:0]    age_years;
    logic [dsc_pkg::MonthW-1:0]   age_months;
    logic [dsc_pkg::DayW-1:0]     extra_days;

    modport source (
        output valid, status, total_days, leap_count, days_before, days_after,
               age_years, age_months, extra_days,
        input  ready
    );
    modport sink (
        input  valid, status, total_days, leap_count, days_before, days_after,
               age_years, age_months, extra_days,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/core/dsc_date_eval.sv
`default_nettype none

module dsc_date_eval (
    input  wire logic [dsc_pkg::MonthW-1:0] i_month,
    input  wire logic [dsc_pkg::DayW-1:0]   i_day,
    input  wire logic [dsc_pkg::YearW-1:0]  i_year,
    output dsc_pkg::t_date_info             o_info
);

    logic [dsc_pkg::Q100W-1:0] q100;
    logic [dsc_pkg::YearW-1:0] q100_x100;
    logic                      cent;
    logic                      leap;
    logic [dsc_pkg::DayW-1:0]  mlen;
    logic [dsc_pkg::LeapW:0]   lt;

    assign q100      = dsc_pkg::f_div100(i_year);
    assign q100_x100 = dsc_pkg::YearW'({5'd0, q100} * 12'd100);
    assign cent      = (q100_x100 == i_year);
    assign leap      = (i_year[1:0] == 2'b00) && (!cent || (q100[1:0] == 2'b00));
    assign mlen      = (i_month == 4'd2 && leap) ? 5'd29 : dsc_pkg::f_month_len_common(i_month);

    // y/4 - y/100 + y/400
    assign lt = {1'b0, i_year[dsc_pkg::YearW-1:2]} - {4'd0, q100} + {6'd0, q100[6:2]};

    assign o_info.valid = (i_month >= 4'd1) && (i_month <= dsc_pkg::MonthW'(dsc_pkg::MonthsPerYear))
                       && (i_year >= 12'd1) && (i_year <= dsc_pkg::YearW'(dsc_pkg::YearMax))
                       && (i_day >= 5'd1) && (i_day <= mlen);
    assign o_info.leap       = leap;
    assign o_info.prior      = dsc_pkg::f_cum_days(i_month)
                             + {8'd0, (i_month > 4'd2) && leap};
    assign o_info.leaps_thru = lt[dsc_pkg::LeapW-1:0];

endmodule

`default_nettype wire

>>> rtl/core/dsc_age_calc.sv
`default_nettype none

module dsc_age_calc (
    input  wire logic [dsc_pkg::MonthW-1:0] i_start_month,
    input  wire logic [dsc_pkg::DayW-1:0]   i_start_day,
    input  wire logic [dsc_pkg::YearW-1:0]  i_start_year,
    input  wire logic [dsc_pkg::MonthW-1:0] i_end_month,
    input  wire logic [dsc_pkg::DayW-1:0]   i_end_day,
    input  wire logic [dsc_pkg::YearW-1:0]  i_end_year,
    output dsc_pkg::t_age                   o_age
);

    logic                       m_borrow;
    logic                       d_borrow;
    logic [dsc_pkg::MonthW-1:0] am0;
    logic                       m_wrap;
    logic [1:0]                 dec;
    logic [dsc_pkg::YearW-1:0]  ay0;
    logic [dsc_pkg::DayW-1:0]   mlen;
    logic [dsc_pkg::DayW-1:0]   ddiff;

    assign m_borrow = i_start_month > i_end_month;
    assign d_borrow = i_end_day < i_start_day;
    assign am0      = m_borrow ? (dsc_pkg::MonthW'(dsc_pkg::MonthsPerYear) + i_end_month
                                  - i_start_month)
                               : (i_end_month - i_start_month);
    assign m_wrap   = d_borrow && (am0 == 4'd0);
    assign dec      = {1'b0, m_borrow} + {1'b0, m_wrap};
    assign ay0      = i_end_year - i_start_year;
    assign mlen     = dsc_pkg::f_month_len_common(i_end_month);
    assign ddiff    = i_start_day - i_end_day;

    always_comb begin
        o_age.years = ({10'd0, dec} > ay0) ? '0 : (ay0 - {10'd0, dec});
        if (!d_borrow) begin
            o_age.months = am0;
            o_age.days   = i_end_day - i_start_day;
        end else begin
            o_age.months = m_wrap ? 4'd11 : (am0 - 4'd1);
            // short end month can undercut the borrow; floor at zero
            o_age.days   = (mlen > ddiff) ? (mlen - ddiff) : '0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/date_span_calculator.sv
// Date span calculator.
// i_req carries one item: a start date and an end date (month, day, year).
// o_res returns exactly one result per item: status, total elapsed days,
// leap years in the span, day of year of the start, days left in the end
// year, and the age as years, months and days. Non-OK status zeroes the rest.
// Both channels are valid/ready; an item moves when both are high.
// Timing: an accepted item passes through the input register, then the result
// register, before o_res.valid rises; a stall on o_res can hold it in either.
// Throughput: one item per cycle while o_res.ready stays high, set by the single
// arithmetic stage between the two registers.
// i_req.ready is high while the input register is empty or its item can move
// into the result register, so items can follow back to back.
// When o_res.ready is low the result holds, the input register fills, and
// then i_req.ready drops; nothing is lost or repeated.
// Reset (i_rst_n low, synchronous) empties both registers; there is no other
// state and no configuration.
`default_nettype none

module date_span_calculator (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dsc_req_if.sink     i_req,
    dsc_res_if.source   o_res
);

    logic                       r_in_valid;
    logic [dsc_pkg::MonthW-1:0] r_bm;
    logic [dsc_pkg::DayW-1:0]   r_bd;
    logic [dsc_pkg::YearW-1:0]  r_by;
    logic [dsc_pkg::MonthW-1:0] r_em;
    logic [dsc_pkg::DayW-1:0]   r_ed;
    logic [dsc_pkg::YearW-1:0]  r_ey;
    logic                       r_out_valid;
    dsc_pkg::t_res              r_res;
    dsc_pkg::t_res              n_res;

    logic                       out_free;
    logic                       in_take;
    dsc_pkg::t_date_info        b_info;
    dsc_pkg::t_date_info        e_info;
    dsc_pkg::t_age              age;
    dsc_pkg::t_status           status;
    logic [dsc_pkg::YearW-1:0]  span;
    logic [dsc_pkg::LeapW-1:0]  lc;
    logic [dsc_pkg::DoyW-1:0]   start_doy;
    logic [dsc_pkg::DoyW-1:0]   after;
    logic [dsc_pkg::DoyW-1:0]   ylen;
    logic [dsc_pkg::TotalW:0]   total;

    assign out_free    = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_in_valid || out_free;
    assign in_take     = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_bm <= i_req.start_month;
            r_bd <= i_req.start_day;
            r_by <= i_req.start_year;
            r_em <= i_req.end_month;
            r_ed <= i_req.end_day;
            r_ey <= i_req.end_year;
        end
    end

    dsc_date_eval u_birth (
        .i_month (r_bm),
        .i_day   (r_bd),
        .i_year  (r_by),
        .o_info  (b_info)
    );

    dsc_date_eval u_end (
        .i_month (r_em),
        .i_day   (r_ed),
        .i_year  (r_ey),
        .o_info  (e_info)
    );

    dsc_age_calc u_age (
        .i_start_month (r_bm),
        .i_start_day   (r_bd),
        .i_start_year  (r_by),
        .i_end_month   (r_em),
        .i_end_day     (r_ed),
        .i_end_year    (r_ey),
        .o_age         (age)
    );

    always_comb begin
        if (!b_info.valid) begin
            status = dsc_pkg::ST_BAD_START;
        end else if (!e_info.valid) begin
            status = dsc_pkg::ST_BAD_END;
        end else if ({r_ey, r_em, r_ed} < {r_by, r_bm, r_bd}) begin
            status = dsc_pkg::ST_ORDER;
        end else begin
            status = dsc_pkg::ST_OK;
        end
    end

    // leaps(1..ey) - leaps(1..by-1)
    assign lc        = e_info.leaps_thru - b_info.leaps_thru + {9'd0, b_info.leap};
    assign span      = r_ey - r_by + 12'd1;
    assign start_doy = b_info.prior + {4'd0, r_bd};
    assign ylen      = e_info.leap ? dsc_pkg::DoyW'(dsc_pkg::DaysLeap)
                                   : dsc_pkg::DoyW'(dsc_pkg::DaysCommon);
    assign after     = ylen - e_info.prior - {4'd0, r_ed};
    assign total     = {10'd0, span} * (dsc_pkg::TotalW+1)'(dsc_pkg::DaysCommon)
                     + {12'd0, lc} - {13'd0, start_doy} - {13'd0, after};

    always_comb begin
        n_res        = '0;
        n_res.status = status;
        if (status == dsc_pkg::ST_OK) begin
            n_res.total_days  = total[dsc_pkg::TotalW-1:0];
            n_res.leap_count  = lc;
            n_res.days_before = start_doy;
            n_res.days_after  = after;
            n_res.age         = age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_res.status;
    assign o_res.total_days  = r_res.total_days;
    assign o_res.leap_count  = r_res.leap_count;
    assign o_res.days_before = r_res.days_before;
    assign o_res.days_after  = r_res.days_after;
    assign o_res.age_years   = r_res.age.years;
    assign o_res.age_months  = r_res.age.months;
    assign o_res.extra_days  = r_res.age.days;

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted item not held in input register");

    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> r_in_valid)
        else $error("input register dropped an item under stall");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status != dsc_pkg::ST_OK) |->
            (o_res.total_days == '0 && o_res.leap_count == '0 && o_res.age_years == '0))
        else $error("error result carries nonzero fields");

    a_months_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.age_months <= 4'd11))
        else $error("age months out of range");

endmodule

`default_nettype wire

>>> test/date_span_calculator_tb.sv
`default_nettype none

module date_span_calculator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RandPerPhase = 150;
    localparam int unsigned HoldCycles   = 300;
    localparam int unsigned TailCycles   = 8;

    typedef struct packed {
        logic [dsc_pkg::MonthW-1:0] b_month;
        logic [dsc_pkg::DayW-1:0]   b_day;
        logic [dsc_pkg::YearW-1:0]  b_year;
        logic [dsc_pkg::MonthW-1:0] e_month;
        logic [dsc_pkg::DayW-1:0]   e_day;
        logic [dsc_pkg::YearW-1:0]  e_year;
    } t_date_pair;

    logic i_clk;
    logic i_rst_n;

    dsc_req_if req_if ();
    dsc_res_if res_if ();

    date_span_calculator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_date_pair     queued_dates[$];
    dsc_pkg::t_res  due_spans[$];
    t_date_pair     next_pair;
    t_date_pair     taken_pair;
    dsc_pkg::t_res  want;
    logic           req_fired;
    logic           rx_hold;
    bit             hold_go;
    int unsigned    tx_idle_pct;
    int unsigned    rx_stall_pct;
    int unsigned    failures;

    // ---------------------------------------------------------------
    // Calendar arithmetic
    // ---------------------------------------------------------------
    function automatic bit greg_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned leaps_upto(input int unsigned y);
        return y / 4 - y / 100 + y / 400;
    endfunction

    function automatic int unsigned common_len(input int unsigned m);
        int unsigned n;
        case (m)
            2:            n = 28;
            4, 6, 9, 11:  n = 30;
            default:      n = 31;
        endcase
        return n;
    endfunction

    function automatic int unsigned mon_days(input int unsigned m, input int unsigned y);
        int unsigned n;
        n = common_len(m);
        if (m == 2 && greg_leap(y))
            n = 29;
        return n;
    endfunction

    function automatic bit date_valid(input int unsigned m, input int unsigned d,
                                      input int unsigned y);
        if (m < 1 || m > dsc_pkg::MonthsPerYear || y < 1 || y > dsc_pkg::YearMax || d < 1)
            return 1'b0;
        return d <= mon_days(m, y);
    endfunction

    function automatic int unsigned days_into_year(input int unsigned m,
                                                   input int unsigned y);
        int unsigned s;
        s = 0;
        for (int unsigned i = 1; i < m && i <= dsc_pkg::MonthsPerYear; i++)
            s += mon_days(i, y);
        return s;
    endfunction

    function automatic int unsigned date_key(input int unsigned m, input int unsigned d,
                                             input int unsigned y);
        return y * 512 + m * 32 + d;
    endfunction

    function automatic dsc_pkg::t_res span_of_dates(input t_date_pair p);
        dsc_pkg::t_res r;
        int unsigned   bm, bd, by, em, ed, ey;
        int unsigned   span, ylen, lc, start_doy, after;
        int            ay, am, ad;
        r  = '0;
        bm = p.b_month; bd = p.b_day; by = p.b_year;
        em = p.e_month; ed = p.e_day; ey = p.e_year;
        if (!date_valid(bm, bd, by)) begin
            r.status = dsc_pkg::ST_BAD_START;
        end else if (!date_valid(em, ed, ey)) begin
            r.status = dsc_pkg::ST_BAD_END;
        end else if (date_key(em, ed, ey) < date_key(bm, bd, by)) begin
            r.status = dsc_pkg::ST_ORDER;
        end else begin
            r.status  = dsc_pkg::ST_OK;
            span      = ey - by + 1;
            ylen      = greg_leap(ey) ? dsc_pkg::DaysLeap : dsc_pkg::DaysCommon;
            lc        = leaps_upto(ey) - leaps_upto(by - 1);
            start_doy = days_into_year(bm, by) + bd;
            after     = ylen - days_into_year(em, ey) - ed;
            r.total_days  = dsc_pkg::TotalW'((span - lc) * dsc_pkg::DaysCommon
                                             + lc * dsc_pkg::DaysLeap - start_doy - after);
            r.leap_count  = dsc_pkg::LeapW'(lc);
            r.days_before = dsc_pkg::DoyW'(start_doy);
            r.days_after  = dsc_pkg::DoyW'(after);

            ay = int'(ey) - int'(by);
            if (bm > em) begin
                ay--;
                am = dsc_pkg::MonthsPerYear - (int'(bm) - int'(em));
            end else begin
                am = int'(em) - int'(bm);
            end
            if (ed < bd) begin
                am--;
                if (am < 0) begin
                    am = dsc_pkg::MonthsPerYear - 1;
                    ay--;
                end
                // borrow uses the common-year length of the end month
                ad = int'(common_len(em)) - (int'(bd) - int'(ed));
                if (ad < 0)
                    ad = 0;
            end else begin
                ad = int'(ed) - int'(bd);
            end
            if (ay < 0)
                ay = 0;
            r.age.years  = dsc_pkg::YearW'(ay);
            r.age.months = dsc_pkg::MonthW'(am);
            r.age.days   = dsc_pkg::DayW'(ad);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic push_pair(input int unsigned bm, input int unsigned bd,
                             input int unsigned by, input int unsigned em,
                             input int unsigned ed, input int unsigned ey);
        t_date_pair p;
        p.b_month = dsc_pkg::MonthW'(bm);
        p.b_day   = dsc_pkg::DayW'(bd);
        p.b_year  = dsc_pkg::YearW'(by);
        p.e_month = dsc_pkg::MonthW'(em);
        p.e_day   = dsc_pkg::DayW'(ed);
        p.e_year  = dsc_pkg::YearW'(ey);
        queued_dates.push_back(p);
    endtask

    task automatic pick_date(input int unsigned lo, input int unsigned hi,
                             output int unsigned m, output int unsigned d,
                             output int unsigned y);
        y = $urandom_range(lo, hi);
        m = $urandom_range(1, dsc_pkg::MonthsPerYear);
        d = $urandom_range(1, mon_days(m, y));
    endtask

    task automatic push_random_pair();
        int unsigned kind, bm, bd, by, em, ed, ey, top;
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
            pick_date(1, dsc_pkg::YearMax, bm, bd, by);
            if ($urandom_range(0, 1) == 0) begin
                top = (by + 3 > dsc_pkg::YearMax) ? dsc_pkg::YearMax : by + 3;
                pick_date(by, top, em, ed, ey);
            end else begin
                pick_date(by, dsc_pkg::YearMax, em, ed, ey);
            end
            // ordered pair mostly; a tenth go in reversed to hit the order check
            if ((date_key(em, ed, ey) < date_key(bm, bd, by)) != (kind >= 70))
                push_pair(em, ed, ey, bm, bd, by);
            else
                push_pair(bm, bd, by, em, ed, ey);
        end else if (kind < 90) begin
            push_pair($urandom_range(1, 12), $urandom_range(0, 31),
                      $urandom_range(1, dsc_pkg::YearMax),
                      $urandom_range(1, 12), $urandom_range(0, 31),
                      $urandom_range(1, dsc_pkg::YearMax));
        end else begin
            push_pair($urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 4095),
                      $urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 4095));
        end
    endtask

    task automatic drain();
        while (queued_dates.size() != 0 || req_if.valid || due_spans.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            failures++;
        end
    endtask

    // ---------------------------------------------------------------
    // Clock, reset, initial drive
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.start_month = '0;
        req_if.start_day   = '0;
        req_if.start_year  = '0;
        req_if.end_month   = '0;
        req_if.end_day     = '0;
        req_if.end_year    = '0;
        res_if.ready       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Driver
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_fired) begin
            if (queued_dates.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                next_pair = queued_dates.pop_front();
                req_if.valid       <= 1'b1;
                req_if.start_month <= next_pair.b_month;
                req_if.start_day   <= next_pair.b_day;
                req_if.start_year  <= next_pair.b_year;
                req_if.end_month   <= next_pair.e_month;
                req_if.end_day     <= next_pair.e_day;
                req_if.end_year    <= next_pair.e_year;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // one long receiver hold-off so the block fills and stalls its input
    initial begin
        rx_hold = 1'b0;
        wait (hold_go);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HoldCycles) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // ---------------------------------------------------------------
    // Monitor and prediction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (due_spans.size() == 0) begin
                    $error("result item with nothing expected");
                    failures++;
                end else begin
                    want = due_spans.pop_front();
                    check_field("status",      want.status,      res_if.status);
                    check_field("total_days",  want.total_days,  res_if.total_days);
                    check_field("leap_count",  want.leap_count,  res_if.leap_count);
                    check_field("days_before", want.days_before, res_if.days_before);
                    check_field("days_after",  want.days_after,  res_if.days_after);
                    check_field("age_years",   want.age.years,   res_if.age_years);
                    check_field("age_months",  want.age.months,  res_if.age_months);
                    check_field("extra_days",  want.age.days,    res_if.extra_days);
                end
            end
            if (req_if.valid && req_if.ready) begin
                taken_pair.b_month = req_if.start_month;
                taken_pair.b_day   = req_if.start_day;
                taken_pair.b_year  = req_if.start_year;
                taken_pair.e_month = req_if.end_month;
                taken_pair.e_day   = req_if.end_day;
                taken_pair.e_year  = req_if.end_year;
                due_spans.push_back(span_of_dates(taken_pair));
            end
        end
        req_fired <= i_rst_n && req_if.valid && req_if.ready;
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial begin
        failures     = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_go      = 1'b0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        @(posedge i_clk);

        // invalid start dates
        push_pair(0, 0, 0, 0, 0, 0);
        push_pair(15, 31, 4095, 15, 31, 4095);
        push_pair(13, 1, 2000, 1, 1, 2000);
        push_pair(2, 29, 1900, 3, 1, 1900);     // century, not leap
        push_pair(4, 31, 2001, 5, 1, 2001);
        push_pair(1, 1, 3001, 1, 1, 3001);
        push_pair(1, 1, 0, 1, 1, 1);
        // invalid end dates
        push_pair(1, 1, 2000, 2, 30, 2000);
        push_pair(1, 1, 2000, 0, 0, 0);
        push_pair(1, 1, 2000, 15, 31, 4095);
        push_pair(1, 1, 2000, 2, 29, 2100);
        // end before start
        push_pair(6, 15, 2000, 6, 14, 2000);
        push_pair(6, 15, 2000, 5, 20, 2000);
        push_pair(6, 15, 2000, 6, 15, 1999);
        // valid spans
        push_pair(2, 29, 2000, 3, 1, 2000);     // leap century
        push_pair(6, 15, 2000, 6, 15, 2000);
        push_pair(1, 1, 1, 12, 31, 3000);
        push_pair(10, 5, 1990, 3, 20, 2020);    // month borrow
        push_pair(3, 20, 1990, 7, 5, 2020);     // day borrow
        push_pair(5, 20, 2000, 5, 10, 2001);    // months wrap to eleven
        push_pair(1, 31, 2000, 2, 1, 2000);     // day borrow clamps at zero
        push_pair(12, 31, 2999, 1, 1, 3000);
        push_pair(2, 29, 2004, 2, 28, 2005);
        push_pair(3, 31, 2023, 2, 28, 2024);
        drain();

        hold_go = 1'b1;
        repeat (RandPerPhase) push_random_pair();
        drain();

        tx_idle_pct = 78;
        repeat (RandPerPhase) push_random_pair();
        drain();

        tx_idle_pct  = 0;
        rx_stall_pct = 78;
        repeat (RandPerPhase) push_random_pair();
        drain();

        tx_idle_pct  = 34;
        rx_stall_pct = 34;
        repeat (RandPerPhase) push_random_pair();
        drain();

        repeat (TailCycles) @(posedge i_clk);
        if (failures == 0)
            $display("[date_span_calculator] OK");
        else
            $display("[date_span_calculator] ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[date_span_calculator] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
